FILE: sv/i8gta_pkg.sv
// ----------------------------------------------------------------------------
// i8gta_pkg
// shared types and constants of the int8 gemm tile accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package i8gta_pkg;

  localparam int TILE_ROWS = 4;
  localparam int TILE_COLS = 4;
  localparam int ROW_W     = 2;
  localparam int DEPTH_W   = 16;

  typedef logic signed [7:0]  elem_t;
  typedef logic signed [15:0] prod_t;
  typedef logic signed [31:0] acc_t;
  typedef logic [ROW_W-1:0]   row_idx_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  typedef elem_t [TILE_ROWS-1:0] a_vec_t;
  typedef elem_t [TILE_COLS-1:0] b_vec_t;
  typedef prod_t [TILE_COLS-1:0] prod_row_t;
  typedef prod_row_t [TILE_ROWS-1:0] prod_tile_t;
  typedef acc_t [TILE_COLS-1:0] acc_row_t;
  typedef acc_row_t [TILE_ROWS-1:0] acc_tile_t;

  // control that travels alongside one reduction step
  typedef struct packed {
    logic valid;
    logic tile_end;
  } step_ctl_t;

endpackage

`default_nettype wire

FILE: sv/i8gta_ifs.sv
// ----------------------------------------------------------------------------
// i8gta channel interfaces
// valid/ready channels for operand beats and result rows
// ----------------------------------------------------------------------------
`default_nettype none

interface i8gta_in_if;
  logic valid;
  logic ready;
  i8gta_pkg::elem_t a_row0;
  i8gta_pkg::elem_t a_row1;
  i8gta_pkg::elem_t a_row2;
  i8gta_pkg::elem_t a_row3;
  i8gta_pkg::elem_t b_col0;
  i8gta_pkg::elem_t b_col1;
  i8gta_pkg::elem_t b_col2;
  i8gta_pkg::elem_t b_col3;

  modport source (
    output valid, a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3,
    input  ready
  );
  modport sink (
    input  valid, a_row0, a_row1, a_row2, a_row3, b_col0, b_col1, b_col2, b_col3,
    output ready
  );
endinterface

interface i8gta_out_if;
  logic valid;
  logic ready;
  i8gta_pkg::acc_t     c_col0;
  i8gta_pkg::acc_t     c_col1;
  i8gta_pkg::acc_t     c_col2;
  i8gta_pkg::acc_t     c_col3;
  i8gta_pkg::row_idx_t row_index;
  logic                last_row;

  modport source (
    output valid, c_col0, c_col1, c_col2, c_col3, row_index, last_row,
    input  ready
  );
  modport sink (
    input  valid, c_col0, c_col1, c_col2, c_col3, row_index, last_row,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/i8gta_mac_array.sv
// ----------------------------------------------------------------------------
// i8gta_mac_array
// registered 8x8 products followed by the 32-bit output-stationary accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module i8gta_mac_array (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  i8gta_pkg::step_ctl_t  s1_ctl,
  input  i8gta_pkg::a_vec_t     a_vec,
  input  i8gta_pkg::b_vec_t     b_vec,
  output i8gta_pkg::step_ctl_t  s2_ctl,
  output i8gta_pkg::acc_tile_t  tile_sum
);
  import i8gta_pkg::*;

  step_ctl_t  s2_ctl_r, s2_ctl_nxt;
  prod_tile_t prod_r, prod_nxt;
  acc_tile_t  acc_r, acc_nxt;
  acc_tile_t  sum;

  // product stage
  always_comb begin
    for (int r = 0; r < TILE_ROWS; r++) begin
      for (int c = 0; c < TILE_COLS; c++) begin
        prod_nxt[r][c] = prod_t'(a_vec[r]) * prod_t'(b_vec[c]);
      end
    end
    s2_ctl_nxt = s1_ctl;
  end

  // accumulate stage, sums wrap modulo 2^32
  always_comb begin
    for (int r = 0; r < TILE_ROWS; r++) begin
      for (int c = 0; c < TILE_COLS; c++) begin
        sum[r][c] = acc_r[r][c] + acc_t'(prod_r[r][c]);
      end
    end
    acc_nxt = acc_r;
    if (en && s2_ctl_r.valid) begin
      acc_nxt = s2_ctl_r.tile_end ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      acc_r    <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (en) begin
        s2_ctl_r <= s2_ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign s2_ctl   = s2_ctl_r;
  assign tile_sum = sum;

endmodule

`default_nettype wire

FILE: sv/int8_gemm_tile_accumulator.sv
// path: tile-ending beat -> input regs -> product regs -> result bank, row 0 valid
// results: four row beats per tile (rows 0..3), one per cycle while out_if.ready is high
// throughput: one operand beat per cycle; a tile end that finds the previous tile's rows
//   still in the result bank holds the pipeline until the last row leaves
// reset: synchronous active-low rst_n clears accumulators, step count, bank full flag; depth = 1
// ----------------------------------------------------------------------------
// int8_gemm_tile_accumulator
// 4x4 output-stationary int8 matrix product tile with int32 accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module int8_gemm_tile_accumulator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  i8gta_pkg::depth_t    cfg_wdata,
  i8gta_in_if.sink             in_if,
  i8gta_out_if.source          out_if
);
  import i8gta_pkg::*;

  // configuration
  depth_t    depth_r;
  depth_t    depth_eff;

  // step counter within the current tile
  depth_t    step_cnt_r, step_cnt_nxt;
  depth_t    step_inc;
  logic      step_end;

  // input register stage
  step_ctl_t s1_ctl_r, s1_ctl_nxt;
  a_vec_t    a_r;
  b_vec_t    b_r;

  // result bank, holds one finished tile while its rows drain
  acc_tile_t bank_r;
  logic      bank_full_r, bank_full_nxt;
  row_idx_t  row_r, row_nxt;

  step_ctl_t s2_ctl;
  acc_tile_t tile_sum;
  logic      en;
  logic      in_beat;
  logic      out_beat;
  logic      tile_done;
  logic      last_row;

  // whole pipeline holds only when a finished tile has nowhere to go;
  // the bank takes the next tile in the cycle its last row leaves
  assign en        = !(s2_ctl.valid && s2_ctl.tile_end && bank_full_r &&
                       !(out_beat && last_row));
  assign in_if.ready = en;
  assign in_beat   = in_if.valid && en;
  assign tile_done = s2_ctl.valid && s2_ctl.tile_end && en;

  // depth of zero behaves as one
  assign depth_eff = (depth_r == '0) ? depth_t'(1) : depth_r;

  // a tile ends once the post-increment count reaches the depth
  always_comb begin
    step_inc     = step_cnt_r + depth_t'(1);
    step_end     = (step_inc == '0) || (step_inc >= depth_eff);
    step_cnt_nxt = step_cnt_r;
    if (in_beat) begin
      step_cnt_nxt = step_end ? '0 : step_inc;
    end
  end

  always_comb begin
    s1_ctl_nxt          = '0;
    s1_ctl_nxt.valid    = in_beat;
    s1_ctl_nxt.tile_end = step_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= depth_t'(1);
      step_cnt_r <= '0;
      s1_ctl_r   <= '0;
    end else begin
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
      step_cnt_r <= step_cnt_nxt;
      if (en) begin
        s1_ctl_r <= s1_ctl_nxt;
      end
    end
  end

  // operand capture, no reset needed on payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      a_r <= {in_if.a_row3, in_if.a_row2, in_if.a_row1, in_if.a_row0};
      b_r <= {in_if.b_col3, in_if.b_col2, in_if.b_col1, in_if.b_col0};
    end
  end

  i8gta_mac_array u_mac_array (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s1_ctl   (s1_ctl_r),
    .a_vec    (a_r),
    .b_vec    (b_r),
    .s2_ctl   (s2_ctl),
    .tile_sum (tile_sum)
  );

  // result bank row sequencing
  assign last_row = (row_r == row_idx_t'(TILE_ROWS - 1));
  assign out_beat = bank_full_r && out_if.ready;

  always_comb begin
    bank_full_nxt = bank_full_r;
    row_nxt       = row_r;
    if (tile_done) begin
      bank_full_nxt = 1'b1;
      row_nxt       = '0;
    end else if (out_beat) begin
      if (last_row) begin
        bank_full_nxt = 1'b0;
        row_nxt       = '0;
      end else begin
        row_nxt = row_r + row_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_full_r <= 1'b0;
      row_r       <= '0;
    end else begin
      bank_full_r <= bank_full_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tile_done) begin
      bank_r <= tile_sum;
    end
  end

  // result channel driven straight from the bank registers
  assign out_if.valid     = bank_full_r;
  assign out_if.c_col0    = bank_r[row_r][0];
  assign out_if.c_col1    = bank_r[row_r][1];
  assign out_if.c_col2    = bank_r[row_r][2];
  assign out_if.c_col3    = bank_r[row_r][3];
  assign out_if.row_index = row_r;
  assign out_if.last_row  = last_row;

endmodule

`default_nettype wire

FILE: sv/i8gta_checker.sv
// ----------------------------------------------------------------------------
// i8gta_checker
// port-level checks on result row sequencing, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module i8gta_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input i8gta_pkg::row_idx_t out_row_index,
  input logic                out_last_row
);
  import i8gta_pkg::*;

  // nothing shows on the result side right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // last flag marks exactly the final row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == row_idx_t'(TILE_ROWS - 1))))
    else $error("last_row does not match row_index");

  // rows of a tile follow back to back in order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_row) |=>
      (out_valid && (out_row_index == $past(out_row_index) + row_idx_t'(1))))
    else $error("row sequence broken");

  // a stalled row beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_row_index)))
    else $error("stalled result beat dropped");

endmodule

bind int8_gemm_tile_accumulator i8gta_checker u_i8gta_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_row_index (out_if.row_index),
  .out_last_row  (out_if.last_row)
);

`default_nettype wire
